// File: hdl/fpba_pkg.sv
// shared types, codes and widths for the fit-policy block allocator
package fpba_pkg;

   // default sizing
   localparam int DEF_NUM_BLOCKS = 8;
   localparam int DEF_SIZE_BITS  = 16;

   // fixed field widths of the ports
   localparam int KIND_W     = 1;
   localparam int BLOCK_W    = 3;
   localparam int AMOUNT_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int REMAIN_W   = 16;
   localparam int POLICY_W   = 2;
   localparam int ACTIVE_W   = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // register reset values
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

   // policy codes, the unused code acts as first fit
   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_BLOCKS = 1'd1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_LOADED = 2'd0,
      STATUS_ALLOC  = 2'd1,
      STATUS_NONE   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   // table port control
   typedef struct packed {
      logic rd;
      logic wr;
   } tbl_ctl_type;

endpackage

// File: hdl/fit_policy_block_allocator_top.sv
// fit-policy block allocator: register file, scan sequencer and result register
//
//   port group  direction  handshake
//   req_*       in         start high and busy low accepts one request
//   rsp_*       out        rsp_strobe marks a result for one cycle, no backpressure
//   csr_*       in         csr_wr_en writes csr_wdata to register csr_index
//
// a load leaves busy low and its result strobes in the next cycle.
// an allocate reads the table one block per cycle over n = min(active_blocks,
// NUM_BLOCKS) blocks: busy stays high through the scan, a drain step for the read
// latency of the memory and the write-back, or only through the write-back when
// no block is active, and the result strobes right after busy falls.
// reset clears the control and configuration registers and the table valid bits at once, no clearing pass.
// results cannot be stalled; each request yields exactly one strobe.
module fit_policy_block_allocator_top import fpba_pkg::*; #(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [BLOCK_W-1:0]    req_block_index,
   input  logic [AMOUNT_W-1:0]   req_amount,
   input  logic                  req_last_request,
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [BLOCK_W-1:0]    rsp_chosen_block,
   output logic [REMAIN_W-1:0]   rsp_remaining_after,
   output logic                  rsp_batch_end,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   logic [POLICY_W-1:0]  fit_policy_ff;
   logic [ACTIVE_W-1:0]  active_blocks_ff;
   int                   active_cnt;

   state_type            state_ff, state_in;
   logic                 accept, load_acc, alloc_acc, load_in_range;
   logic [SIZE_BITS-1:0] amt_sz;

   logic [SIZE_BITS-1:0] amt_ff;
   logic                 last_ff;
   logic [IDX_W-1:0]     last_addr_ff;
   logic [IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                 eval_ff;
   logic [IDX_W-1:0]     eval_idx_ff;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic [SIZE_BITS-1:0] new_cap;
   logic [SIZE_BITS-1:0] cap;
   logic                 fits, take;

   tbl_ctl_type          tbl_ctl;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [BLOCK_W-1:0]   rsp_chosen_ff, rsp_chosen_in;
   logic [REMAIN_W-1:0]  rsp_remain_ff, rsp_remain_in;
   logic                 rsp_end_ff, rsp_end_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff    <= POLICY_FIRST;
         active_blocks_ff <= ACTIVE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIT_POLICY:    fit_policy_ff    <= csr_wdata[POLICY_W-1:0];
            CSR_ACTIVE_BLOCKS: active_blocks_ff <= csr_wdata[ACTIVE_W-1:0];
            default: ;
         endcase
      end
   end

   assign active_cnt = (int'(active_blocks_ff) > NUM_BLOCKS) ? NUM_BLOCKS
                                                               : int'(active_blocks_ff);

   assign accept        = start && !busy;
   assign load_acc      = accept && (req_kind == KIND_LOAD);
   assign alloc_acc     = accept && (req_kind == KIND_ALLOC);
   assign load_in_range = int'(req_block_index) < NUM_BLOCKS;
   assign amt_sz        = SIZE_BITS'(req_amount);
   assign new_cap       = best_ff - amt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (alloc_acc) begin
               state_in = (active_cnt == 0) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_ptr_ff == last_addr_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy       = 1'b1;
      tbl_ctl.rd = 1'b0;
      tbl_ctl.wr = 1'b0;
      wr_addr    = IDX_W'(req_block_index);
      wr_data    = amt_sz;
      unique case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            tbl_ctl.wr = load_acc && load_in_range;
         end
         ST_SCAN: begin
            tbl_ctl.rd = 1'b1;
         end
         ST_DRAIN: ;
         ST_WRITE: begin
            tbl_ctl.wr = found_ff;
            wr_addr    = pick_ff;
            wr_data    = new_cap;
         end
         default: ;
      endcase
   end

   fpba_table #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .rd_addr (rd_ptr_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (cap)
   );

   // compare the block read last cycle against the best so far
   assign fits = cap >= amt_ff;
   assign take = eval_ff && fits &&
                 (!found_ff ||
                  ((fit_policy_ff == POLICY_BEST)  && (cap < best_ff)) ||
                  ((fit_policy_ff == POLICY_WORST) && (cap > best_ff)));

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (alloc_acc) begin
         rd_ptr_in = '0;
      end else if (state_ff == ST_SCAN) begin
         rd_ptr_in = rd_ptr_ff + IDX_W'(1);
      end
      found_in = alloc_acc ? 1'b0 : (found_ff || (eval_ff && fits));
      pick_in  = take ? eval_idx_ff : pick_ff;
      best_in  = take ? cap : best_ff;
   end

   // result of the current request
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_remain_in = rsp_remain_ff;
      rsp_end_in    = rsp_end_ff;
      if (load_acc) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = STATUS_LOADED;
         rsp_chosen_in = req_block_index;
         rsp_remain_in = load_in_range ? REMAIN_W'(amt_sz) : '0;
         rsp_end_in    = req_last_request;
      end else if (state_ff == ST_WRITE) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = found_ff ? STATUS_ALLOC : STATUS_NONE;
         rsp_chosen_in = found_ff ? BLOCK_W'(pick_ff) : '0;
         rsp_remain_in = found_ff ? REMAIN_W'(new_cap) : '0;
         rsp_end_in    = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         eval_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         eval_ff       <= (state_ff == ST_SCAN);
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc_acc) begin
         amt_ff       <= amt_sz;
         last_ff      <= req_last_request;
         last_addr_ff <= IDX_W'(active_cnt - 1);
      end
      rd_ptr_ff     <= rd_ptr_in;
      eval_idx_ff   <= rd_ptr_ff;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_remain_ff <= rsp_remain_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_chosen_block    = rsp_chosen_ff;
   assign rsp_remaining_after = rsp_remain_ff;
   assign rsp_batch_end       = rsp_end_ff;

   // a strobe follows either a load or the write-back step
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(load_acc || (state_ff == ST_WRITE)))
      else $error("result strobe without a finished request");

   // a failed allocation reports no block and no capacity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_NONE)) |->
         ((rsp_chosen_block == '0) && (rsp_remaining_after == '0)))
      else $error("failed allocation carries block data");

   // table data is only evaluated right after a scan read
   assert property (@(posedge clock) disable iff (reset)
      eval_ff |-> $past(state_ff == ST_SCAN))
      else $error("evaluation without a table read");

   // the write-back always returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> (state_ff == ST_IDLE))
      else $error("write-back did not end the request");

   // no request is taken while a scan is running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !accept)
      else $error("request accepted during a scan");

endmodule

// File: hdl/fpba_table.sv
// capacity table: one synchronous memory with per-entry valid bits
module fpba_table import fpba_pkg::*; #(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS,
   localparam int IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tbl_ctl_type          ctl,
   input  logic [IDX_W-1:0]     rd_addr,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [SIZE_BITS-1:0] wr_data,
   output logic [SIZE_BITS-1:0] rd_data
);

   logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] valid_ff;
   logic [SIZE_BITS-1:0]  rd_data_ff;
   logic                  rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule
